// ===== src/wssm_pkg.sv =====
// ----------------------------------------------------------------------------
// wssm_pkg
// shared types and constants of the windowed steady-state mean block
// ----------------------------------------------------------------------------
`default_nettype none

package wssm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TOL_W       = 11;
    localparam int COUNT_OUT_W = 7;
    localparam int STEADY_W    = 24;
    localparam int FRAC_W      = 8;
    localparam int TOL_SHIFT   = 10;
    localparam int LIMIT_W     = SAMPLE_W + TOL_W;

    localparam logic [TOL_W-1:0] TOL_RESET = 11'd102;

    // input word
    typedef struct packed {
        logic                clear;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    // result word
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] fill_count;
        logic [SAMPLE_W-1:0]    mean;
        logic [STEADY_W-1:0]    steady_mean;
    } result_t;

    typedef enum logic {
        CMD_PUSH,
        CMD_CLEAR
    } cmd_op_t;

    // classified command handed from front to back
    typedef struct packed {
        cmd_op_t             op;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_MEAN,
        ST_LIMIT,
        ST_BAND,
        ST_DIV_STEADY,
        ST_OUT,
        ST_SPARE
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/wssm_front.sv =====
// ----------------------------------------------------------------------------
// wssm_front
// accepts input words, classifies them and queues two commands for the back
// ----------------------------------------------------------------------------
`default_nettype none

module wssm_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire wssm_pkg::item_t item,
    input  wire logic            cmd_pop,
    output logic                 cmd_valid,
    output wssm_pkg::cmd_t       cmd
);
    import wssm_pkg::*;

    cmd_t       q_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;
    cmd_t       cmd_in;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op     = item.clear ? CMD_CLEAR : CMD_PUSH;
        cmd_in.sample = item.sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

// ===== src/wssm_div.sv =====
// ----------------------------------------------------------------------------
// wssm_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module wssm_div #(
    parameter int DW = 31,
    parameter int VW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);
    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   dsr_reg;
    logic [DW-1:0]   quo_reg;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign diff     = trial - {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/wssm_back.sv =====
// ----------------------------------------------------------------------------
// wssm_back
// window memory, up to two passes over the held samples, up to two divisions, result stage
// ----------------------------------------------------------------------------
`default_nettype none

module wssm_back #(
    parameter int WINDOW = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [wssm_pkg::TOL_W-1:0]     tolerance,
    input  wire logic                           cmd_valid,
    input  wire wssm_pkg::cmd_t                 cmd,
    output logic                                cmd_pop,
    output logic                                empty,
    input  wire logic                           pop,
    output wssm_pkg::result_t                   result
);
    import wssm_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = $clog2(WINDOW);
    localparam int SW = SAMPLE_W + CW;
    localparam int DW = SAMPLE_W + FRAC_W + CW;

    back_state_t         state_reg, state_next;
    logic [SAMPLE_W-1:0] win_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic                rvalid_reg;
    logic [SW-1:0]       acc_reg, acc_next;
    logic [CW-1:0]       band_n_reg, band_n_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [STEADY_W-1:0] steady_reg, steady_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    result_t             res_reg, res_next;
    logic                res_valid_reg, res_valid_next;
    logic                issue;
    logic                mem_we;
    logic [SAMPLE_W-1:0] abs_diff;
    logic                in_band;
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [CW-1:0]       div_divisor;
    logic                div_done;
    logic [DW-1:0]       div_quotient;

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(WINDOW - 1) : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

    wssm_div #(
        .DW(DW),
        .VW(CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign rd_addr  = ptr_dec(rd_ptr_reg);
    assign issue    = ((state_reg == ST_SUM) || (state_reg == ST_BAND)) && (iss_reg != count_reg);
    assign abs_diff = (rd_data_reg >= mean_reg) ? (rd_data_reg - mean_reg)
                                                : (mean_reg - rd_data_reg);
    assign in_band  = (LIMIT_W'({abs_diff, {TOL_SHIFT{1'b0}}}) <= limit_reg);
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        iss_next       = iss_reg;
        acc_next       = acc_reg;
        band_n_next    = band_n_reg;
        mean_next      = mean_reg;
        steady_next    = steady_reg;
        limit_next     = limit_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (pop && res_valid_reg)
            res_valid_next = 1'b0;

        if (issue)
        begin
            rd_ptr_next = rd_addr;
            iss_next    = iss_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = ptr_inc(wr_ptr_reg);
                        if (count_reg != CW'(WINDOW))
                            count_next = count_reg + 1'b1;
                    end
                    rd_ptr_next = wr_ptr_next;
                    iss_next    = '0;
                    acc_next    = '0;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (rvalid_reg)
                    acc_next = acc_reg + SW'(rd_data_reg);
                if (!issue && !rvalid_reg)
                begin
                    if (count_reg == '0)
                    begin
                        mean_next   = '0;
                        steady_next = '0;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = DW'(acc_reg);
                        div_divisor  = count_reg;
                        state_next   = ST_DIV_MEAN;
                    end
                end
            end
            ST_DIV_MEAN:
            begin
                if (div_done)
                begin
                    mean_next  = div_quotient[SAMPLE_W-1:0];
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                limit_next = LIMIT_W'(mean_reg) * LIMIT_W'(tolerance);
                if (mean_reg == '0)
                begin
                    steady_next = '0;
                    state_next  = ST_OUT;
                end
                else
                begin
                    rd_ptr_next = wr_ptr_reg;
                    iss_next    = '0;
                    acc_next    = '0;
                    band_n_next = '0;
                    state_next  = ST_BAND;
                end
            end
            ST_BAND:
            begin
                if (rvalid_reg && in_band)
                begin
                    acc_next    = acc_reg + SW'(rd_data_reg);
                    band_n_next = band_n_reg + 1'b1;
                end
                if (!issue && !rvalid_reg)
                begin
                    if (band_n_reg == '0)
                    begin
                        steady_next = STEADY_W'({mean_reg, {FRAC_W{1'b0}}});
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = {acc_reg, {FRAC_W{1'b0}}};
                        div_divisor  = band_n_reg;
                        state_next   = ST_DIV_STEADY;
                    end
                end
            end
            ST_DIV_STEADY:
            begin
                if (div_done)
                begin
                    steady_next = div_quotient[STEADY_W-1:0];
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_next)
                begin
                    res_next.fill_count  = COUNT_OUT_W'(count_reg);
                    res_next.mean        = mean_reg;
                    res_next.steady_mean = steady_reg;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            iss_reg       <= '0;
            rvalid_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            iss_reg       <= iss_next;
            rvalid_reg    <= issue;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        acc_reg    <= acc_next;
        band_n_reg <= band_n_next;
        mean_reg   <= mean_next;
        steady_reg <= steady_next;
        limit_reg  <= limit_next;
        res_reg    <= res_next;
    end

    // window memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[wr_ptr_reg] <= cmd.sample;
        if (issue)
            rd_data_reg <= win_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/window_steady_state_mean.sv =====
// ----------------------------------------------------------------------------
// window_steady_state_mean
// sliding window mean of current samples with a steady-state mean that
// rejects samples outside a tolerance band around the mean
// ----------------------------------------------------------------------------
//  channel   ports                           word accepted when
//  input     push, full, item                push && !full
//  result    empty, pop, result              pop && !empty
//  config    cfg_we, cfg_wdata (tolerance)   cfg_we
//
//  an item is worked on in up to two read passes through the window memory,
//  one entry per cycle, and up to two runs of the serial divider, one bit
//  per cycle on a DW = 24 + clog2(WINDOW+1) bit dividend
//  reset clears the queues, the fill count and the window write pointer; memory is not swept
//  a stalled result waits in the output stage while the next item is worked
//  on; the back stalls only when a second result is ready
// ----------------------------------------------------------------------------
`default_nettype none

module window_steady_state_mean #(
    parameter int WINDOW = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input queue side
    input  wire logic                       push,
    output logic                            full,
    input  wire wssm_pkg::item_t            item,
    // result queue side
    output logic                            empty,
    input  wire logic                       pop,
    output wssm_pkg::result_t               result,
    // tolerance register write
    input  wire logic                       cfg_we,
    input  wire logic [wssm_pkg::TOL_W-1:0] cfg_wdata
);
    import wssm_pkg::*;

    // tolerance band in 1/1024 of the mean, keeps its value across clears
    logic [TOL_W-1:0] tolerance_reg;

    // classified commands from the front to the back
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= TOL_RESET;
        else if (cfg_we)
            tolerance_reg <= cfg_wdata;
    end

    // front: takes words, tags clear or push, holds two commands
    wssm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // back: updates the window, sums, divides, filters and holds the result
    wssm_back #(
        .WINDOW(WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tolerance (tolerance_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== src/wssm_checker.sv =====
// ----------------------------------------------------------------------------
// wssm_checker
// port-level checks on the result channel of the steady-state mean block
// ----------------------------------------------------------------------------
`default_nettype none

module wssm_checker #(
    parameter int WINDOW = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              full,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire wssm_pkg::result_t result
);
    import wssm_pkg::*;

    // fill count fits the result field only for small windows
    localparam bit NARROW = (WINDOW < 128);

    a_reset_queues: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not empty during reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        NARROW && !empty |-> result.fill_count <= COUNT_OUT_W'(WINDOW))
        else $error("fill count above window size");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        NARROW && !empty && result.fill_count == '0 |->
            result.mean == '0 && result.steady_mean == '0)
        else $error("empty window reports nonzero means");

    a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.mean == '0 |-> result.steady_mean == '0)
        else $error("zero mean with nonzero steady mean");

endmodule

bind window_steady_state_mean wssm_checker #(
    .WINDOW(WINDOW)
) u_wssm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the windowed steady-state mean block against a local predictor of
// the sample window; words flow through the push and pop queue ports with
// random idle bursts on both sides, the tolerance register is rewritten
// between phases, and one phase holds the result side off long enough
// that the input side stalls
// ----------------------------------------------------------------------------

module tb;

    import wssm_pkg::*;

    localparam int WIN_DEPTH  = 64;
    localparam int CLK_HALF   = 6;
    // watchdog cap sized for about 1800 slowest-case items plus the idling
    // on the two sides
    localparam int CYCLE_CAP  = 2500000;
    localparam int DRAIN_WAIT = 250;
    localparam int LONG_HOLD  = 6000;

    // ------------------------------------------------------------------
    // predictor of the window and store of expected result words
    // ------------------------------------------------------------------
    class mean_scoreboard;
        logic [SAMPLE_W-1:0] window_q[$];   // newest first
        logic [TOL_W-1:0]    tol;
        result_t             pending_results[$];
        int unsigned         errors;

        function new();
            tol    = TOL_RESET;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // update the window with an accepted word and queue the means it gives
        function void note_word(item_t w);
            longint unsigned total, band_total, band_n, avg, lim, x, d, steady;
            result_t         r;
            int              k;
            total      = 0;
            band_total = 0;
            band_n     = 0;
            avg        = 0;
            steady     = 0;
            if (w.clear)
                window_q.delete();
            else
            begin
                window_q.push_front(w.sample);
                if (window_q.size() > WIN_DEPTH)
                    void'(window_q.pop_back());
            end
            if (window_q.size() != 0)
            begin
                for (k = 0; k < window_q.size(); k++)
                    total += window_q[k];
                avg = total / window_q.size();
                if (avg != 0)
                begin
                    // band test kept exact: |x - mean| * 1024 <= mean * tol
                    lim = avg * tol;
                    for (k = 0; k < window_q.size(); k++)
                    begin
                        x = window_q[k];
                        d = (x >= avg) ? x - avg : avg - x;
                        if (d * 1024 <= lim)
                        begin
                            band_total += x;
                            band_n++;
                        end
                    end
                    // nothing in band falls back to the plain mean in q8
                    steady = (band_n == 0) ? (avg << 8) : ((band_total << 8) / band_n);
                end
            end
            r.fill_count  = COUNT_OUT_W'(window_q.size());
            r.mean        = avg[SAMPLE_W-1:0];
            r.steady_mean = steady[STEADY_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void match_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result word, expected none, actual %0d/%0d/%0d",
                         $time, got.fill_count, got.mean, got.steady_mean);
                return;
            end
            want = pending_results.pop_front();
            match_field("fill_count", want.fill_count, got.fill_count);
            match_field("mean", want.mean, got.mean);
            match_field("steady_mean", want.steady_mean, got.steady_mean);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    item_t            item;
    logic             empty;
    logic             pop;
    result_t          result;
    logic             cfg_we;
    logic [TOL_W-1:0] cfg_wdata;

    window_steady_state_mean #(
        .WINDOW(WIN_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    mean_scoreboard sb;

    // shared knobs between the sending flow and the result process
    bit          calm;          // no idling at all in the closing phase
    int unsigned hold_cycles;   // long result-side hold requested by the sender
    int unsigned cycle_count;

    // shape of the random samples: a drifting level with noise and outliers
    int unsigned level;
    int unsigned spread;
    int unsigned clear_pct;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_CAP)
            begin
                $display("FAIL window_steady_state_mean");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one word and hold it until the block takes it; push stays high
    // so back-to-back words need no second assignment in the same step
    task automatic send_word(input item_t w);
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
        sb.note_word(w);
    endtask

    task automatic idle_sender(input int unsigned n);
        push <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random gap after a word, skipped in the calm phase
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 18));
    endtask

    // sender pause: nothing offered until every result word is back
    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // only written with the block idle, i.e. after drain_results
    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.tol = v;
    endtask

    task automatic send_push(input logic [SAMPLE_W-1:0] s);
        item_t w;
        w.clear  = 1'b0;
        w.sample = s;
        send_word(w);
    endtask

    task automatic send_clear(input logic [SAMPLE_W-1:0] junk);
        item_t w;
        w.clear  = 1'b1;
        w.sample = junk;
        send_word(w);
    endtask

    // random word: mostly a noisy steady level, some wild values and extremes
    function automatic item_t pick_word();
        item_t       w;
        int unsigned r;
        int          v;
        r        = $urandom_range(0, 99);
        w.clear  = (r < clear_pct);
        w.sample = SAMPLE_W'($urandom);
        if (w.clear)
        begin
            // new window, new operating point
            level  = $urandom_range(0, 65535);
            spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, level / 16 + 2);
        end
        else if (r < 70)
        begin
            v = int'(level) + int'($urandom_range(0, 2 * spread)) - int'(spread);
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            w.sample = SAMPLE_W'(v);
        end
        else if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       w.sample = 16'h0000;
                1:       w.sample = 16'hFFFF;
                2:       w.sample = SAMPLE_W'($urandom_range(0, 3));
                default: w.sample = 16'hFFFF - SAMPLE_W'($urandom_range(0, 3));
            endcase
        end
        return w;
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            send_word(pick_word());
            maybe_gap();
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin
        pop <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_cycles != 0)
            begin
                // long hold so the block backs up and raises full
                pop <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
                // values seen here are the ones the edge acted on
                if (!empty)
                    sb.check_word(result);
            end
        end
    end

    // ------------------------------------------------------------------
    // main flow
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned i;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        item        <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        calm        = 1'b0;
        hold_cycles = 0;
        level       = 1000;
        spread      = 20;
        clear_pct   = 3;
        sb          = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset tolerance
        send_clear(16'hFFFF);       // empty window reports zeros
        send_push(16'h0000);        // zero mean
        send_push(16'h0000);
        send_push(16'hFFFF);        // top of the sample range
        send_push(16'hFFFF);
        send_push(16'hFFFF);
        send_clear(16'h0000);
        send_push(16'd100);         // mean 200, both samples outside the band
        send_push(16'd300);
        send_push(16'd200);         // now one sample sits right on the mean
        send_push(16'hFFFF);
        send_push(16'h0000);

        // zero tolerance keeps only samples equal to the mean
        drain_results();
        write_tolerance(11'd0);
        send_clear(16'h5A5A);
        send_push(16'd500);
        send_push(16'd500);
        send_push(16'd500);
        send_push(16'd501);

        // full-width band
        drain_results();
        write_tolerance(11'd1024);
        run_random(300);

        // narrowest nonzero band; long result hold while words keep coming
        drain_results();
        write_tolerance(11'd1);
        run_random(100);
        hold_cycles = LONG_HOLD;
        for (i = 0; i < 60; i++)
            send_word(pick_word());
        run_random(140);

        // widest band the register holds; frequent clears keep windows short
        drain_results();
        write_tolerance(11'h7FF);
        clear_pct = 15;
        run_random(300);

        drain_results();
        write_tolerance(TOL_W'($urandom_range(0, 2047)));
        clear_pct = 3;
        run_random(300);

        drain_results();
        write_tolerance(TOL_RESET);
        run_random(275);

        // closing phase runs with no idling on either side
        drain_results();
        write_tolerance(TOL_W'($urandom_range(0, 2047)));
        calm = 1'b1;
        run_random(275);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS window_steady_state_mean");
        else
            $display("FAIL window_steady_state_mean");
        $finish;
    end

endmodule

// ===== sim.f =====
src/wssm_pkg.sv
src/wssm_front.sv
src/wssm_div.sv
src/wssm_back.sv
src/window_steady_state_mean.sv
src/wssm_checker.sv
bench/tb.sv
